@@ rtl/color_wheel_pixel_to_hsv_top_assert.svh @@
// Assertion macros for the color wheel mapper.
`ifndef COLOR_WHEEL_PIXEL_TO_HSV_TOP_ASSERT_SVH
`define COLOR_WHEEL_PIXEL_TO_HSV_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Plain condition checked on every clock edge outside reset.
`define CW_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`endif

@@ rtl/cwhsv_pkg.sv @@
//------------------------------------------------------------------------------
// cwhsv_pkg
// Shared types, register indexes and tables for the color wheel mapper.
//------------------------------------------------------------------------------
package cwhsv_pkg;

    localparam int COORD_BITS_DEF   = 12;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    localparam int CFG_IDX_BITS     = 2;
    localparam int CFG_DATA_BITS    = 12;

    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_VALUE    = 2'd3;

    typedef struct packed {
        logic [11:0] point_x;
        logic [11:0] point_y;
    } pixel_t;

    typedef struct packed {
        logic       inside_res;
        logic [8:0] hue_degrees;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } hsv_t;

    // Angle class found before the CORDIC.
    typedef enum logic [1:0] {
        ANG_CORDIC = 2'd0,
        ANG_EXACT  = 2'd1,
        ANG_CENTER = 2'd2
    } ang_kind_t;

    // atan(2^-i) in units of 2^-16 degree.
    function automatic logic [21:0] atan_lut(input int i);
        logic [21:0] v;
        unique case (i)
            0:  v = 22'd2949120;
            1:  v = 22'd1740967;
            2:  v = 22'd919879;
            3:  v = 22'd466945;
            4:  v = 22'd234379;
            5:  v = 22'd117304;
            6:  v = 22'd58666;
            7:  v = 22'd29335;
            8:  v = 22'd14668;
            9:  v = 22'd7334;
            10: v = 22'd3667;
            11: v = 22'd1833;
            12: v = 22'd917;
            13: v = 22'd458;
            14: v = 22'd229;
            15: v = 22'd115;
            16: v = 22'd57;
            17: v = 22'd29;
            18: v = 22'd14;
            19: v = 22'd7;
            20: v = 22'd4;
            21: v = 22'd2;
            22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/cwhsv_cordic_stage.sv @@
//------------------------------------------------------------------------------
// cwhsv_cordic_stage
// One registered vectoring CORDIC micro-rotation with a fixed shift.
//------------------------------------------------------------------------------
module cwhsv_cordic_stage #(
    parameter int XW    = 32,
    parameter int ZW    = 26,
    parameter int SHIFT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic                 out_valid,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);
    import cwhsv_pkg::*;

    logic signed [XW-1:0] x_next, y_next, xs, ys;
    logic signed [ZW-1:0] z_next, ang;
    logic                 valid_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;

    always_comb
    begin
        xs  = x_in >>> SHIFT;
        ys  = y_in >>> SHIFT;
        ang = ZW'(signed'({1'b0, atan_lut(SHIFT)}));
        if (!y_in[XW-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ang;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
endmodule

@@ rtl/cwhsv_isqrt.sv @@
//------------------------------------------------------------------------------
// cwhsv_isqrt
// Pipelined floor square root, one result bit per stage.
//------------------------------------------------------------------------------
module cwhsv_isqrt #(
    parameter int NW = 48,
    parameter int RW = 24
) (
    input  logic          clk,
    input  logic [NW-1:0] n_in,
    output logic [RW-1:0] root_out
);
    import cwhsv_pkg::*;

    logic [NW-1:0] rem_reg  [RW+1];
    logic [RW-1:0] root_reg [RW+1];

    always_comb
    begin
        rem_reg[0]  = n_in;
        root_reg[0] = '0;
    end

    for (genvar k = 0; k < RW; k++)
    begin : g_bit
        localparam int B = RW - 1 - k;
        logic [NW+1:0] trial;
        logic [NW-1:0] rem_next;
        logic [RW-1:0] root_next;
        always_comb
        begin
            trial = ({2'b00, (NW)'(root_reg[k])} << (B + 1))
                  + ({{(NW+1){1'b0}}, 1'b1} << (2 * B));
            if ({2'b00, rem_reg[k]} >= trial)
            begin
                rem_next  = rem_reg[k] - NW'(trial);
                root_next = root_reg[k] | (RW'(1) << B);
            end
            else
            begin
                rem_next  = rem_reg[k];
                root_next = root_reg[k];
            end
        end
        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next;
            root_reg[k+1] <= root_next;
        end
    end

    assign root_out = root_reg[RW];
endmodule

@@ rtl/cwhsv_divider.sv @@
//------------------------------------------------------------------------------
// cwhsv_divider
// Pipelined restoring divider giving an 8-bit saturated quotient.
//------------------------------------------------------------------------------
module cwhsv_divider #(
    parameter int NW = 24,
    parameter int DW = 11
) (
    input  logic          clk,
    input  logic [NW-1:0] num_in,
    input  logic [DW-1:0] den_in,
    output logic [7:0]    quot_out
);
    import cwhsv_pkg::*;

    // Quotient saturates at 255: first test quotient >= 256, then 8 bits.
    logic [NW-1:0] rem_reg [10];
    logic [DW-1:0] den_reg [10];
    logic [7:0]    q_reg   [10];
    logic          sat_reg [10];

    always_comb
    begin
        rem_reg[0] = num_in;
        den_reg[0] = den_in;
        q_reg[0]   = '0;
        sat_reg[0] = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[1] <= rem_reg[0];
        den_reg[1] <= den_reg[0];
        q_reg[1]   <= '0;
        sat_reg[1] <= ({{8{1'b0}}, rem_reg[0]} >= ({{NW{1'b0}}, den_reg[0]} << 8));
    end

    for (genvar k = 0; k < 8; k++)
    begin : g_q
        localparam int B = 7 - k;
        logic [NW+DW:0] dsh;
        logic [NW-1:0]  rem_next;
        logic [7:0]     q_next;
        always_comb
        begin
            dsh = {{(NW+1){1'b0}}, den_reg[k+1]} << B;
            if (!sat_reg[k+1] && ({{(DW+1){1'b0}}, rem_reg[k+1]} >= dsh))
            begin
                rem_next = rem_reg[k+1] - NW'(dsh);
                q_next   = q_reg[k+1] | (8'd1 << B);
            end
            else
            begin
                rem_next = rem_reg[k+1];
                q_next   = q_reg[k+1];
            end
        end
        always_ff @(posedge clk)
        begin
            rem_reg[k+2] <= rem_next;
            den_reg[k+2] <= den_reg[k+1];
            q_reg[k+2]   <= q_next;
            sat_reg[k+2] <= sat_reg[k+1];
        end
    end

    assign quot_out = sat_reg[9] ? 8'hFF : q_reg[9];
endmodule

@@ rtl/color_wheel_pixel_to_hsv_top.sv @@
// Timing: done follows the accepting edge via stage 1, stage 2, the longer of the
//   CORDIC and saturation paths, and the output register; both are padded to match.
// Throughput: one word per cycle; busy is tied low since every stage is a
//   plain pipeline register and the receiver cannot stall.
// Reset: rst_n clears valid bits and returns registers to center 0, radius 1,
//   value 255; payload registers hold no reset.
//------------------------------------------------------------------------------
// color_wheel_pixel_to_hsv_top
// Maps a pixel coordinate to HSV on a color wheel: CORDIC hue, sqrt/divide
// saturation, all in one deep pipeline.
//------------------------------------------------------------------------------
module color_wheel_pixel_to_hsv_top #(
    parameter int COORD_BITS   = cwhsv_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS = cwhsv_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  cwhsv_pkg::pixel_t                   pixel,
    output logic                                done,
    output cwhsv_pkg::hsv_t                     hsv,
    input  logic                                cfg_we,
    input  logic [cwhsv_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [cwhsv_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import cwhsv_pkg::*;

    localparam int DW    = COORD_BITS + 1;            // signed delta
    localparam int DSQW  = 2 * COORD_BITS + 1;        // d
    localparam int NW    = DSQW + 16;                 // 65025*d
    localparam int RW    = (NW + 1) / 2;              // sqrt bits
    localparam int SQLAT = RW;                        // isqrt latency
    localparam int SATLAT = SQLAT + 10;               // product, isqrt, divider
    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int XW    = DW + 16 + 3;
    localparam int ZW    = 26;
    localparam int LAT   = (STEPS > SATLAT) ? STEPS : SATLAT;

    // ---- configuration registers ----
    logic [11:0] center_x_reg, center_y_reg;
    logic [10:0] radius_reg;
    logic [7:0]  value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= 11'd1;
            value_reg    <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_RADIUS:   radius_reg   <= cfg_data[10:0];
                REG_VALUE:    value_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---- stage 1: deltas ----
    logic                 s1_valid_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start;
    end
    always_ff @(posedge clk)
    begin
        dx_reg <= signed'({1'b0, COORD_BITS'(pixel.point_x)})
                - signed'({1'b0, COORD_BITS'(center_x_reg)});
        dy_reg <= signed'({1'b0, COORD_BITS'(pixel.point_y)})
                - signed'({1'b0, COORD_BITS'(center_y_reg)});
    end

    // ---- stage 2: squares, angle class, CORDIC entry ----
    logic [DW-1:0]   ax, ay;
    logic [DSQW-1:0] d_reg;
    logic [21:0]     rsq_reg;
    logic            s2_valid_reg;
    ang_kind_t       kind_next, kind_reg;
    logic signed [9:0] exact_next, exact_reg;
    logic signed [XW-1:0] x0_next, y0_next, x0_reg, y0_reg;
    logic signed [ZW-1:0] z0_next, z0_reg;

    always_comb
    begin
        ax = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
        ay = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
        exact_next = '0;
        kind_next  = ANG_EXACT;
        if (dx_reg == 0 && dy_reg == 0)
            kind_next = ANG_CENTER;
        else if (dy_reg == 0)
            exact_next = dx_reg[DW-1] ? 10'sd180 : 10'sd0;
        else if (dx_reg == 0)
            exact_next = dy_reg[DW-1] ? -10'sd90 : 10'sd90;
        else if (ax == ay)
        begin
            if (!dx_reg[DW-1])
                exact_next = dy_reg[DW-1] ? -10'sd45 : 10'sd45;
            else
                exact_next = dy_reg[DW-1] ? -10'sd135 : 10'sd135;
        end
        else
            kind_next = ANG_CORDIC;
        // Fold the left half plane by +-180 degrees.
        if (dx_reg[DW-1])
        begin
            x0_next = XW'(-dx_reg) <<< 16;
            y0_next = XW'(-dy_reg) <<< 16;
            z0_next = dy_reg[DW-1] ? -ZW'(180 * 65536) : ZW'(180 * 65536);
        end
        else
        begin
            x0_next = XW'(dx_reg) <<< 16;
            y0_next = XW'(dy_reg) <<< 16;
            z0_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end
    always_ff @(posedge clk)
    begin
        d_reg     <= DSQW'(ax * ax) + DSQW'(ay * ay);
        rsq_reg   <= radius_reg * radius_reg;
        kind_reg  <= kind_next;
        exact_reg <= exact_next;
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        z0_reg    <= z0_next;
    end

    // ---- CORDIC chain: one micro-rotation per stage ----
    logic signed [XW-1:0] cx [STEPS+1];
    logic signed [XW-1:0] cy [STEPS+1];
    logic signed [ZW-1:0] cz [STEPS+1];
    logic                 cv [STEPS+1];
    assign cx[0] = x0_reg;
    assign cy[0] = y0_reg;
    assign cz[0] = z0_reg;
    assign cv[0] = s2_valid_reg;
    for (genvar i = 0; i < STEPS; i++)
    begin : g_cordic
        cwhsv_cordic_stage #(.XW(XW), .ZW(ZW), .SHIFT(i)) u_stage (
            .clk(clk), .rst_n(rst_n), .in_valid(cv[i]),
            .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]),
            .out_valid(cv[i+1]), .x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1])
        );
    end

    // Delay line for angle class and exact angle alongside CORDIC.
    ang_kind_t         kind_dl  [STEPS+1];
    logic signed [9:0] exact_dl [STEPS+1];
    assign kind_dl[0]  = kind_reg;
    assign exact_dl[0] = exact_reg;
    for (genvar i = 0; i < STEPS; i++)
    begin : g_kdl
        always_ff @(posedge clk)
        begin
            kind_dl[i+1]  <= kind_dl[i];
            exact_dl[i+1] <= exact_dl[i];
        end
    end

    // ---- saturation path: sqrt then divide ----
    logic [NW-1:0] prod_reg;
    logic [RW-1:0] root;
    logic [7:0]    quot;
    logic [10:0]   rad_dl [SQLAT+2];
    always_ff @(posedge clk)
    begin
        prod_reg <= NW'(d_reg) * NW'(65025);
    end
    assign rad_dl[0] = radius_reg;
    for (genvar i = 0; i <= SQLAT; i++)
    begin : g_rdl
        always_ff @(posedge clk) rad_dl[i+1] <= rad_dl[i];
    end
    cwhsv_isqrt #(.NW(NW), .RW(RW)) u_sqrt (.clk(clk), .n_in(prod_reg), .root_out(root));
    cwhsv_divider #(.NW(RW), .DW(11)) u_div (
        .clk(clk), .num_in(root), .den_in(rad_dl[SQLAT+1]), .quot_out(quot)
    );
    // Zero radius: the divider saturates anyway; fix the center to 0.
    logic            dz_dl  [SATLAT+1];
    logic            ins_dl [SATLAT+1];
    logic [7:0]      val_dl [SATLAT+1];
    assign dz_dl[0]  = (d_reg == 0);
    assign ins_dl[0] = (64'(d_reg) <= 64'(rsq_reg));
    assign val_dl[0] = value_reg;
    for (genvar i = 0; i < SATLAT; i++)
    begin : g_sdl
        always_ff @(posedge clk)
        begin
            dz_dl[i+1]  <= dz_dl[i];
            ins_dl[i+1] <= ins_dl[i];
            val_dl[i+1] <= val_dl[i];
        end
    end
    logic [7:0] sat_val;
    assign sat_val = dz_dl[SATLAT] ? 8'd0 : quot;

    // Align the two paths: pad the shorter one.
    localparam int HPAD = LAT - STEPS;
    localparam int SPAD = LAT - SATLAT;
    logic signed [ZW-1:0] zh [HPAD+1];
    ang_kind_t            kh [HPAD+1];
    logic signed [9:0]    eh [HPAD+1];
    logic                 vh [HPAD+1];
    assign zh[0] = cz[STEPS];
    assign kh[0] = kind_dl[STEPS];
    assign eh[0] = exact_dl[STEPS];
    assign vh[0] = cv[STEPS];
    for (genvar i = 0; i < HPAD; i++)
    begin : g_hp
        always_ff @(posedge clk)
        begin
            zh[i+1] <= zh[i];
            kh[i+1] <= kh[i];
            eh[i+1] <= eh[i];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) vh[i+1] <= 1'b0;
            else        vh[i+1] <= vh[i];
        end
    end
    logic [7:0] sp  [SPAD+1];
    logic       ip  [SPAD+1];
    logic [7:0] vp  [SPAD+1];
    assign sp[0] = sat_val;
    assign ip[0] = ins_dl[SATLAT];
    assign vp[0] = val_dl[SATLAT];
    for (genvar i = 0; i < SPAD; i++)
    begin : g_sp
        always_ff @(posedge clk)
        begin
            sp[i+1] <= sp[i];
            ip[i+1] <= ip[i];
            vp[i+1] <= vp[i];
        end
    end

    // ---- final stage: truncate angle, offset, wrap ----
    logic signed [ZW-1:0] zq;
    logic signed [9:0]    deg;
    logic signed [10:0]   hsum;
    logic [8:0]           hue_next;
    always_comb
    begin
        // Truncate toward zero: bias negatives before the shift.
        zq = zh[HPAD][ZW-1] ? (zh[HPAD] + ZW'(65535)) : zh[HPAD];
        unique case (kh[HPAD])
            ANG_CORDIC: deg = 10'(zq >>> 16);
            ANG_EXACT:  deg = eh[HPAD];
            default:    deg = 10'sd0;
        endcase
        hsum = 11'sd270 + 11'(deg);
        if (kh[HPAD] == ANG_CENTER)
            hue_next = 9'd270;
        else if (hsum >= 11'sd360)
            hue_next = 9'(hsum - 11'sd360);
        else if (hsum < 0)
            hue_next = 9'(hsum + 11'sd360);
        else
            hue_next = 9'(hsum);
    end

    logic done_reg;
    hsv_t hsv_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= vh[HPAD];
    end
    always_ff @(posedge clk)
    begin
        hsv_reg.inside_res  <= ip[SPAD];
        hsv_reg.hue_degrees <= hue_next;
        hsv_reg.saturation  <= sp[SPAD];
        hsv_reg.brightness  <= vp[SPAD];
    end

    assign done = done_reg;
    assign hsv  = hsv_reg;
endmodule

@@ rtl/cwhsv_checker.sv @@
//------------------------------------------------------------------------------
// cwhsv_checker
// Port-level checks on the color wheel mapper, bound to the top level.
//------------------------------------------------------------------------------
`include "color_wheel_pixel_to_hsv_top_assert.svh"
module cwhsv_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input cwhsv_pkg::hsv_t   hsv
);
    import cwhsv_pkg::*;

    `CW_ASSERT_ALWAYS(a_never_busy, !busy)
    `CW_ASSERT_IMPL(a_hue_range, done, hsv.hue_degrees < 9'd360)
    `CW_ASSERT_IMPL(a_inside_sat, done && hsv.inside_res, hsv.saturation <= 8'd255)
    `CW_ASSERT_IMPL(a_outside_full, done && !hsv.inside_res, hsv.saturation == 8'd255)
endmodule

bind color_wheel_pixel_to_hsv_top cwhsv_checker u_cwhsv_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .hsv(hsv)
);
